[hw/rtl/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg: shared types and helpers for the string literal escaper
// Beat formats for both channels, register map and character-class helpers.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned MaxRun   = 8;  // bytes one input beat can produce
  localparam int unsigned RunIdxW  = $clog2(MaxRun);
  localparam int unsigned RunCntW  = $clog2(MaxRun + 1);
  localparam int unsigned AddrW    = 3;

  localparam logic [AddrW-1:0] RegQuoteAddr = 3'd0;

  localparam logic [6:0] ChBackslash = 7'h5C;
  localparam logic [6:0] ChLowerX    = 7'h78;
  localparam logic [6:0] ChLowerU    = 7'h75;

  typedef struct packed {
    logic [15:0] char_code;
    logic        starts_string;
    logic        ends_string;
    logic        no_char;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Uppercase hex digit for one nibble
  function automatic logic [6:0] hex_digit(input logic [3:0] n);
    logic [6:0] r;
    if (n < 4'd10) r = 7'h30 + {3'b000, n};
    else           r = 7'h37 + {3'b000, n};
    return r;
  endfunction

  // Two-character escape letter; returns hit flag in bit 7
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h08:   r = {1'b1, 7'h62};  // b
      8'h0C:   r = {1'b1, 7'h66};  // f
      8'h0A:   r = {1'b1, 7'h6E};  // n
      8'h0D:   r = {1'b1, 7'h72};  // r
      8'h09:   r = {1'b1, 7'h74};  // t
      8'h0B:   r = {1'b1, 7'h76};  // v
      8'h22:   r = {1'b1, 7'h22};
      8'h27:   r = {1'b1, 7'h27};
      8'h5C:   r = {1'b1, 7'h5C};
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/string_literal_escaper.sv]
// ----------------------------------------------------------------------------
// string_literal_escaper: 16-bit character stream to escaped ASCII bytes
// Wraps strings in the configured quote and escapes each character in the
// style of a JavaScript string literal.
// ----------------------------------------------------------------------------
// Each input beat expands to zero to eight output bytes, one output beat per
// cycle while out_stall is low; last_of_run marks the final byte of a beat. An
// accepted beat sits in a one-entry input register, is expanded
// combinationally into the run buffer, and the run buffer then drains one byte
// per cycle while out_stall is low. A new input beat is taken every cycle
// while the run buffer turns over, so the sustained input rate is set by the
// single output byte lane. quote_char sits at byte address 0; write it only
// while the block is idle.
module string_literal_escaper
  import sle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,

  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,

  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,

  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [6:0] quote_char;

  in_item_t   hold;
  logic       hold_valid;

  logic [6:0]         run_bytes [MaxRun];
  logic [RunCntW-1:0] run_cnt;
  logic [RunIdxW-1:0] run_idx;
  logic               run_valid;

  logic run_last, run_done, run_free, move, in_take;

  logic [6:0]         exp_bytes [MaxRun];
  logic [RunCntW-1:0] exp_cnt;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = {25'd0, quote_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_char <= '0;
    end else if (psel && penable && pwrite && paddr[AddrW-1] == RegQuoteAddr[AddrW-1]) begin
      quote_char <= pwdata[6:0];
    end
  end

  // Handshake control
  assign run_last  = ({1'b0, run_idx} == run_cnt - 1'b1);
  assign run_done  = run_valid && !out_stall && run_last;
  assign run_free  = !run_valid || run_done;
  assign move      = hold_valid && run_free;
  assign in_stall  = hold_valid && !run_free;
  assign in_take   = in_valid && !in_stall;

  assign out_valid            = run_valid;
  assign out_data.out_byte    = run_bytes[run_idx];
  assign out_data.last_of_run = run_last;

  // Expansion of the held beat
  always_comb begin
    logic [7:0]   lo;
    logic         hi_zero, quoting, printable, pre, suf;
    logic [7:0]   map;
    logic [6:0]   body [MaxRun];
    logic [2:0]   blen;
    logic [3:0]   k;

    lo        = hold.char_code[7:0];
    hi_zero   = (hold.char_code[15:8] == 8'd0);
    quoting   = (quote_char != 7'd0);
    printable = hi_zero && lo >= 8'h20 && lo < 8'h7F &&
                lo != {1'b0, quote_char} && lo != {1'b0, ChBackslash};
    map       = esc_map(lo);
    pre       = hold.starts_string && quoting;
    suf       = hold.ends_string && quoting;

    for (int i = 0; i < MaxRun; i++) body[i] = '0;
    body[0] = ChBackslash;

    if (printable) begin
      body[0] = lo[6:0];
      blen    = 3'd1;
    end else if (hi_zero && lo != 8'd0 && map[7]) begin
      body[1] = map[6:0];
      blen    = 3'd2;
    end else if (quoting && hi_zero) begin
      body[1] = ChLowerX;
      body[2] = hex_digit(hold.char_code[7:4]);
      body[3] = hex_digit(hold.char_code[3:0]);
      blen    = 3'd4;
    end else begin
      body[1] = ChLowerU;
      body[2] = hex_digit(hold.char_code[15:12]);
      body[3] = hex_digit(hold.char_code[11:8]);
      body[4] = hex_digit(hold.char_code[7:4]);
      body[5] = hex_digit(hold.char_code[3:0]);
      blen    = 3'd6;
    end
    if (hold.no_char) blen = 3'd0;

    // quote, body, quote packed from slot 0
    for (int i = 0; i < MaxRun; i++) begin
      k = 4'(i) - {3'b000, pre};
      if (pre && i == 0)              exp_bytes[i] = quote_char;
      else if (k < {1'b0, blen})      exp_bytes[i] = body[k[RunIdxW-1:0]];
      else                            exp_bytes[i] = quote_char;
    end
    exp_cnt = {3'b000, pre} + {1'b0, blen} + {3'b000, suf};
  end

  // Input register and run buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      run_valid  <= 1'b0;
      run_idx    <= '0;
      run_cnt    <= '0;
    end else begin
      if (in_take) begin
        hold       <= in_data;
        hold_valid <= 1'b1;
      end else if (move) begin
        hold_valid <= 1'b0;
      end

      if (move) begin
        run_valid <= (exp_cnt != '0);
        run_cnt   <= exp_cnt;
        run_idx   <= '0;
        for (int i = 0; i < MaxRun; i++) run_bytes[i] <= exp_bytes[i];
      end else if (run_done) begin
        run_valid <= 1'b0;
      end else if (run_valid && !out_stall) begin
        run_idx <= run_idx + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/sle_checker.sv]
// ----------------------------------------------------------------------------
// sle_checker: port-level checks for the string literal escaper
// Bound to the top level; watches the channels and register port only.
// ----------------------------------------------------------------------------
module sle_checker
  import sle_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input out_item_t        out_data,
  input logic             pready
);

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Input only backs up behind a pending output run
  a_stall_has_run: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no output pending");

  // Stall only rises after a beat was taken into the input register
  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && in_stall && !$past(in_stall) |-> $past(in_valid))
    else $error("input stall rose without an accepted beat");

  // Every escaped byte is printable, a quote, or an escape letter: never zero
  a_byte_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.out_byte != 7'd0 && pready)
    else $error("zero output byte");

endmodule

bind string_literal_escaper sle_checker u_sle_checker (.*);
